@@ src/scba_pkg.sv @@
// package for the size class bucket allocator
// shared constants, state codes and helper functions; no dependencies
`default_nettype none
package scba_pkg;
    localparam int PAGE_BYTES  = 4096;
    localparam int SLOTS       = 256;
    localparam int SLOT_W      = 9;
    localparam int CLASS_W     = 4;
    localparam int MAX_CLASSES = 9;
    localparam int REF_W       = 16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_PAGES = 2'd2;
    localparam logic [1:0] ST_BAD_ADDR = 2'd3;

    localparam logic [31:0] PAGE_MASK = 32'hffff_f000;
    localparam logic [8:0]  NULL_SLOT = 9'd256;

    // class size 16 << c
    function automatic logic [12:0] class_size(input logic [3:0] c);
        class_size = 13'd16 << c;
    endfunction
endpackage
`default_nettype wire

@@ src/scba_if.sv @@
// valid/ready channel interface for the allocator
// depends on nothing
`default_nettype none
interface scba_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [15:0] request_len;
    logic [31:0] free_addr;
    logic [12:0] size_hint;
    modport source (output valid, req_type, request_len, free_addr, size_hint, input ready);
    modport sink   (input valid, req_type, request_len, free_addr, size_hint, output ready);
endinterface

interface scba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] obj_addr;
    logic [12:0] granted_size;
    modport source (output valid, status, obj_addr, granted_size, input ready);
    modport sink   (input valid, status, obj_addr, granted_size, output ready);
endinterface

interface scba_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

@@ src/scba_ram.sv @@
// generic single port ram with registered read
// no dependencies
`default_nettype none
module scba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_addr,
    input  wire [WIDTH-1:0]          i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

@@ src/size_class_bucket_allocator.sv @@
// top level of the size class bucket allocator: sequencer, page descriptor ram and slot ram
// depends on scba_pkg, scba_if and scba_ram
//
// One request is taken at a time. The request and configuration channels are only
// ready while the block is idle with no result waiting. An allocation steps through
// the classes in order from the 16 byte class until one fits. It then walks the class
// chain, reading each page descriptor until a page with a free slot is found, and pops
// that slot from the page's free list in the slot ram. When the chain has no free
// slot, the pool is scanned in page order for an unused page; its slots are threaded
// into a free list in the slot ram (256 for the 16 byte class, 1 for the 4096 byte
// class) and the page is put at the head of the chain. A too large request answers
// with ST_TOO_BIG after the class search. A full pool answers with ST_NO_PAGES after
// the chain walk and a scan of every page. A free reads the page descriptor of its
// address before it answers, unless the address is outside the pool or in an unused
// page. When a free releases a page that is not at the head of its chain, it walks
// the chain to unlink it. The result sits in an output register until taken. The next
// request can be taken in the cycle after the result transaction.
`default_nettype none
module size_class_bucket_allocator
    import scba_pkg::*;
#(
    parameter int NUM_PAGES   = 64,
    parameter int NUM_CLASSES = 9
) (
    input  wire i_clk,
    input  wire i_rst_n,
    scba_cfg_if.sink   cfg,
    scba_req_if.sink   req,
    scba_rsp_if.source rsp
);
    localparam int PW  = $clog2(NUM_PAGES + 1);
    localparam int PIW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int CIW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int RAW = PIW + 8;
    localparam int DW  = CLASS_W + REF_W + SLOT_W + PW;
    localparam logic [PW-1:0] NULL_PAGE = PW'(NUM_PAGES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLS   = 4'd1;
    localparam logic [3:0] S_WALK  = 4'd2;
    localparam logic [3:0] S_WCHK  = 4'd3;
    localparam logic [3:0] S_FIND  = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_POPRD = 4'd6;
    localparam logic [3:0] S_POP   = 4'd7;
    localparam logic [3:0] S_FDEC  = 4'd8;
    localparam logic [3:0] S_FRD   = 4'd9;
    localparam logic [3:0] S_FCHK  = 4'd10;
    localparam logic [3:0] S_UNLK  = 4'd11;
    localparam logic [3:0] S_UCHK  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]         r_state;
    logic [31:0]        r_base;
    logic [NUM_PAGES-1:0] r_used;
    logic [PW-1:0]      r_chead [NUM_CLASSES];

    logic [15:0]        r_len;
    logic [31:0]        r_addr;
    logic [12:0]        r_hint;
    logic [CLASS_W-1:0] r_cls;
    logic [PW-1:0]      r_p;
    logic [PW-1:0]      r_q;
    logic [PW-1:0]      r_pn;
    logic [PW-1:0]      r_steps;
    logic [8:0]         r_i;
    logic [8:0]         r_slot;
    logic [CLASS_W-1:0] r_dcls;
    logic [REF_W-1:0]   r_dref;
    logic [PW-1:0]      r_dnext;
    logic [1:0]         r_st;
    logic [31:0]        r_oaddr;
    logic [12:0]        r_osize;
    logic               r_ovalid;

    // shared slot ram port
    logic              ram_we;
    logic [RAW-1:0]    ram_addr;
    logic [SLOT_W-1:0] ram_wdata, ram_rdata;

    // page descriptor ram port: class, count, free head, chain link
    logic              pg_we;
    logic [PIW-1:0]    pg_addr;
    logic [DW-1:0]     pg_wdata, pg_rdata;

    scba_ram #(.WIDTH(SLOT_W), .DEPTH((2 ** PIW) * SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(ram_wdata), .o_rdata(ram_rdata)
    );

    scba_ram #(.WIDTH(DW), .DEPTH(2 ** PIW)) u_page_ram (
        .i_clk(i_clk), .i_we(pg_we), .i_addr(pg_addr),
        .i_wdata(pg_wdata), .o_rdata(pg_rdata)
    );

    assign cfg.ready = (r_state == S_IDLE) && !r_ovalid;
    assign req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid = r_ovalid;
    assign rsp.status = r_st;
    assign rsp.obj_addr = r_oaddr;
    assign rsp.granted_size = r_osize;

    logic [CLASS_W-1:0] pd_cls;
    logic [REF_W-1:0]   pd_ref;
    logic [SLOT_W-1:0]  pd_fhead;
    logic [PW-1:0]      pd_next;
    assign {pd_cls, pd_ref, pd_fhead, pd_next} = pg_rdata;

    logic [PIW-1:0] p_i, q_i;
    logic [CIW-1:0] c_i, fc_i;
    logic [12:0]    size;
    logic [8:0]     nslots;
    logic [31:0]    fdiff;
    logic [19:0]    fpage;
    logic [11:0]    foff;
    logic [12:0]    fsize;
    logic [8:0]     fslot;
    logic           free_ok;
    assign p_i = r_p[PIW-1:0];
    assign q_i = r_q[PIW-1:0];
    assign c_i = r_cls[CIW-1:0];
    assign fc_i = pd_cls[CIW-1:0];
    assign size = class_size(r_cls);
    assign nslots = 9'(13'(PAGE_BYTES) >> (r_cls + 4'd4));
    assign fdiff = (r_addr & PAGE_MASK) - (r_base & PAGE_MASK);
    assign fpage = fdiff[31:12];
    assign foff  = r_addr[11:0];
    assign fsize = class_size(pd_cls);
    assign fslot = 9'({1'b0, foff} >> (pd_cls + 4'd4));
    assign free_ok = (32'(pd_cls) < NUM_CLASSES) && (fsize >= r_hint)
                     && ((13'(foff) & (fsize - 13'd1)) == 13'd0);

    always_comb begin
        ram_we = 1'b0;
        ram_addr = {p_i, r_i[7:0]};
        ram_wdata = '0;
        unique case (r_state)
            S_FILL: begin
                ram_we = 1'b1;
                ram_wdata = (r_i + 9'd1 == nslots) ? NULL_SLOT : r_i + 9'd1;
            end
            S_POPRD: ram_addr = {p_i, r_slot[7:0]};
            S_FCHK: begin
                ram_we = free_ok;
                ram_addr = {p_i, fslot[7:0]};
                ram_wdata = pd_fhead;
            end
            default: ;
        endcase
    end

    always_comb begin
        pg_we = 1'b0;
        pg_addr = p_i;
        pg_wdata = '0;
        unique case (r_state)
            S_POP: begin
                pg_we = 1'b1;
                pg_wdata = {r_dcls, r_dref + 16'd1, ram_rdata, r_dnext};
            end
            S_FCHK: begin
                pg_we = free_ok;
                pg_wdata = {pd_cls, pd_ref - 16'd1, fslot, pd_next};
            end
            S_UNLK: pg_addr = q_i;
            S_UCHK: begin
                pg_addr = q_i;
                pg_we = (pd_next == r_p);
                pg_wdata = {pd_cls, pd_ref, pd_fhead, r_pn};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base <= '0;
            r_ovalid <= 1'b0;
            r_used <= '0;
            for (int k = 0; k < NUM_CLASSES; k++) r_chead[k] <= NULL_PAGE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (rsp.valid && rsp.ready) r_ovalid <= 1'b0;
                    if (cfg.valid && cfg.ready) r_base <= cfg.data;
                    if (req.valid && req.ready) begin
                        r_len  <= req.request_len;
                        r_addr <= req.free_addr;
                        r_hint <= req.size_hint;
                        r_steps <= '0;
                        r_cls <= '0;
                        if (req.req_type) begin
                            r_state <= S_FDEC;
                        end else begin
                            r_state <= S_CLS;
                        end
                    end
                end
                S_CLS: begin
                    // class search, one class per cycle
                    if (r_len > 16'(size)) begin
                        if (32'(r_cls) + 1 >= NUM_CLASSES) begin
                            r_st <= ST_TOO_BIG;
                            r_state <= S_OUT;
                        end else begin
                            r_cls <= r_cls + 4'd1;
                        end
                    end else begin
                        r_p <= r_chead[c_i];
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_p >= NULL_PAGE || 32'(r_steps) >= NUM_PAGES) begin
                        r_p <= '0;
                        r_state <= S_FIND;
                    end else begin
                        r_state <= S_WCHK;
                    end
                end
                S_WCHK: begin
                    if (pd_fhead < NULL_SLOT) begin
                        r_slot <= pd_fhead;
                        r_dcls <= pd_cls;
                        r_dref <= pd_ref;
                        r_dnext <= pd_next;
                        r_state <= S_POPRD;
                    end else begin
                        r_p <= pd_next;
                        r_steps <= r_steps + PW'(1);
                        r_state <= S_WALK;
                    end
                end
                S_FIND: begin
                    if (r_p >= NULL_PAGE) begin
                        r_st <= ST_NO_PAGES;
                        r_state <= S_OUT;
                    end else if (!r_used[p_i]) begin
                        r_i <= 9'd0;
                        r_state <= S_FILL;
                    end else begin
                        r_p <= r_p + PW'(1);
                    end
                end
                S_FILL: begin
                    if (r_i + 9'd1 == nslots) begin
                        r_used[p_i] <= 1'b1;
                        r_dcls <= r_cls;
                        r_dref <= '0;
                        r_dnext <= r_chead[c_i];
                        r_chead[c_i] <= r_p;
                        r_slot <= '0;
                        r_state <= S_POPRD;
                    end else begin
                        r_i <= r_i + 9'd1;
                    end
                end
                S_POPRD: r_state <= S_POP;
                S_POP: begin
                    r_st <= ST_OK;
                    r_oaddr <= (r_base & PAGE_MASK) + (32'(r_p) << 12)
                               + (32'(r_slot) << (r_cls + 4'd4));
                    r_osize <= size;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_FDEC: begin
                    if (fpage >= 20'(NUM_PAGES) || !r_used[fpage[PIW-1:0]]) begin
                        r_st <= ST_BAD_ADDR;
                        r_state <= S_OUT;
                    end else begin
                        r_p <= PW'(fpage);
                        r_state <= S_FRD;
                    end
                end
                S_FRD: r_state <= S_FCHK;
                S_FCHK: begin
                    if (!free_ok) begin
                        r_st <= ST_BAD_ADDR;
                        r_state <= S_OUT;
                    end else begin
                        r_st <= ST_OK;
                        if (pd_ref == 16'd1) begin
                            r_used[p_i] <= 1'b0;
                            if (r_chead[fc_i] == r_p) begin
                                r_chead[fc_i] <= pd_next;
                                r_state <= S_OUT;
                            end else begin
                                r_q <= r_chead[fc_i];
                                r_pn <= pd_next;
                                r_state <= S_UNLK;
                            end
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_UNLK: begin
                    if (r_q >= NULL_PAGE || 32'(r_steps) >= NUM_PAGES) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_UCHK;
                    end
                end
                S_UCHK: begin
                    if (pd_next == r_p) begin
                        r_state <= S_OUT;
                    end else begin
                        r_q <= pd_next;
                        r_steps <= r_steps + PW'(1);
                        r_state <= S_UNLK;
                    end
                end
                S_OUT: begin
                    r_oaddr <= '0;
                    r_osize <= '0;
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !req.ready) else $error("ready while busy");
    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.granted_size == 13'd0)
        else $error("size on error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid) else $error("result lost");
endmodule
`default_nettype wire
